// ===== design/etu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etu_pkg
// Shared constants, result type and reciprocal constants for the epoch
// seconds to UTC date converter.
// ----------------------------------------------------------------------------
package etu_pkg;

    // default width of the signed epoch count
    localparam int EPOCH_BITS_DEF = 40;

    // time of day
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    // 86400 = 675 * 2^7: the low seven bits bypass the long divider
    localparam int DAY_SHIFT = 7;
    localparam int DAY_ODD   = 675;

    // civil calendar, eras of 400 years starting on March 1
    localparam int DAYS_PER_ERA      = 146097;
    localparam int DAYS_TO_1970      = 719468;
    localparam int YEARS_PER_ERA     = 400;

    // long division: quotient bits resolved per pipeline stage
    localparam int DIV_STEP_BITS = 4;

    // widths inside the calendar pipeline
    localparam int DOE_W     = 18;
    localparam int REM_DAY_W = 17;

    // exact division by constants: q = (n * M) >> S with S = N + ceil(log2 d)
    localparam int          SH_1460  = 29;
    localparam logic [47:0] M_1460   = ((48'd1 << SH_1460) + 48'd1459) / 48'd1460;
    localparam int          SH_36524 = 34;
    localparam logic [47:0] M_36524  = ((48'd1 << SH_36524) + 48'd36523) / 48'd36524;
    localparam int          SH_3600  = 29;
    localparam logic [47:0] M_3600   = ((48'd1 << SH_3600) + 48'd3599) / 48'd3600;
    localparam int          SH_365   = 27;
    localparam logic [47:0] M_365    = ((48'd1 << SH_365) + 48'd364) / 48'd365;
    localparam int          SH_60    = 18;
    localparam logic [47:0] M_60     = ((48'd1 << SH_60) + 48'd59) / 48'd60;
    localparam int          SH_100   = 16;
    localparam logic [47:0] M_100    = ((48'd1 << SH_100) + 48'd99) / 48'd100;
    localparam int          SH_153   = 19;
    localparam logic [47:0] M_153    = ((48'd1 << SH_153) + 48'd152) / 48'd153;
    localparam int          SH_5     = 14;
    localparam logic [47:0] M_5      = ((48'd1 << SH_5) + 48'd4) / 48'd5;

    // one converted item
    typedef struct packed {
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [4:0]        day;
        logic [3:0]        month;
        logic signed [15:0] year;
    } t_date_time;

endpackage

// ===== design/etu_cdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etu_cdiv
// Pipelined long division of an unsigned value by a constant, a few
// quotient bits per stage, with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module etu_cdiv
    import etu_pkg::*;
#(
    parameter int NUM_W     = 34,
    parameter int DIVISOR   = DAY_ODD,
    parameter int SIDE_W    = DAY_SHIFT,
    parameter int STEP_BITS = DIV_STEP_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [NUM_W-1:0]           o_quo,
    output logic [$clog2(DIVISOR)-1:0] o_rem,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int RW = $clog2(DIVISOR);
    localparam int NS = (NUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PW = NS * STEP_BITS;
    localparam logic [RW:0] DIV_V = (RW+1)'(DIVISOR);

    logic [RW-1:0]     r_rem  [NS];
    logic [PW-1:0]     r_x    [NS];
    logic [SIDE_W-1:0] r_side [NS];
    logic [NS-1:0]     r_vld;

    logic [RW-1:0]     c_rem_in  [NS];
    logic [PW-1:0]     c_x_in    [NS];
    logic [SIDE_W-1:0] c_side_in [NS];
    logic [NS-1:0]     c_vld_in;
    logic [RW-1:0]     c_rem_out [NS];
    logic [PW-1:0]     c_x_out   [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        // stage inputs: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign c_rem_in[k]  = '0;
            assign c_x_in[k]    = PW'(i_num);
            assign c_side_in[k] = i_side;
            assign c_vld_in[k]  = i_valid;
        end else begin : g_next
            assign c_rem_in[k]  = r_rem[k-1];
            assign c_x_in[k]    = r_x[k-1];
            assign c_side_in[k] = r_side[k-1];
            assign c_vld_in[k]  = r_vld[k-1];
        end

        // restoring division steps, quotient bits shift in at the bottom
        always_comb begin : step
            logic [RW:0]   t;
            logic [RW-1:0] rem;
            logic [PW-1:0] x;
            rem = c_rem_in[k];
            x   = c_x_in[k];
            for (int g = 0; g < STEP_BITS; g++) begin
                t = {rem, x[PW-1]};
                x = {x[PW-2:0], 1'b0};
                if (t >= DIV_V) begin
                    t    = t - DIV_V;
                    x[0] = 1'b1;
                end
                rem = t[RW-1:0];
            end
            c_rem_out[k] = rem;
            c_x_out[k]   = x;
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= c_rem_out[k];
                r_x[k]    <= c_x_out[k];
                r_side[k] <= c_side_in[k];
            end
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_vld_in[k];
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_x[NS-1][NUM_W-1:0];
    assign o_rem   = r_rem[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// ===== design/etu_civil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etu_civil
// Nine-stage pipeline from era, day of era and second of day to year,
// month, day, hour, minute and second.
// ----------------------------------------------------------------------------
module etu_civil
    import etu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [15:0]          i_era,
    input  logic [DOE_W-1:0]     i_doe,
    input  logic [REM_DAY_W-1:0] i_rem_day,
    output logic                 o_valid,
    output t_date_time           o_result
);

    logic [8:0] r_vld;

    // stage 1
    logic [15:0]          r1_era400;
    logic [DOE_W-1:0]     r1_doe;
    logic [REM_DAY_W-1:0] r1_rem;
    logic [6:0]           r1_a1;
    logic [2:0]           r1_a2;
    logic                 r1_a3;
    logic [4:0]           r1_hour;
    // stage 2
    logic [DOE_W-1:0]     r2_t;
    logic [11:0]          r2_mrem;
    logic [DOE_W-1:0]     r2_doe;
    logic [15:0]          r2_era400;
    logic [4:0]           r2_hour;
    // stage 3
    logic [8:0]           r3_yoe;
    logic [5:0]           r3_min;
    logic [11:0]          r3_mrem;
    logic [DOE_W-1:0]     r3_doe;
    logic [15:0]          r3_era400;
    logic [4:0]           r3_hour;
    // stage 4
    logic [DOE_W-1:0]     r4_y365;
    logic [6:0]           r4_y4;
    logic [1:0]           r4_y100;
    logic [15:0]          r4_yb;
    logic [5:0]           r4_sec;
    logic [DOE_W-1:0]     r4_doe;
    logic [4:0]           r4_hour;
    logic [5:0]           r4_min;
    // stage 5
    logic [8:0]           r5_doy;
    logic [15:0]          r5_yb;
    logic [4:0]           r5_hour;
    logic [5:0]           r5_min;
    logic [5:0]           r5_sec;
    // stage 6
    logic [10:0]          r6_v;
    logic [8:0]           r6_doy;
    logic [15:0]          r6_yb;
    logic [4:0]           r6_hour;
    logic [5:0]           r6_min;
    logic [5:0]           r6_sec;
    // stage 7
    logic [3:0]           r7_mp;
    logic [8:0]           r7_doy;
    logic [15:0]          r7_yb;
    logic [4:0]           r7_hour;
    logic [5:0]           r7_min;
    logic [5:0]           r7_sec;
    // stage 8
    logic [10:0]          r8_w;
    logic [3:0]           r8_month;
    logic [15:0]          r8_year;
    logic [8:0]           r8_doy;
    logic [4:0]           r8_hour;
    logic [5:0]           r8_min;
    logic [5:0]           r8_sec;
    // stage 9
    t_date_time           r9_res;

    // products of the reciprocal multipliers
    logic [47:0] p_a1, p_a2, p_hour, p_yoe, p_min, p_y100, p_mp, p_w5;
    logic [31:0] p_era;
    logic [REM_DAY_W-1:0] c_mrem;
    logic [11:0]          c_sec;
    logic [DOE_W-1:0]     c_doy;
    logic [8:0]           c_day;

    assign p_a1   = 48'(i_doe) * M_1460;
    assign p_a2   = 48'(i_doe) * M_36524;
    assign p_hour = 48'(i_rem_day) * M_3600;
    assign p_era  = 32'(i_era) * 32'(YEARS_PER_ERA);
    assign c_mrem = r1_rem - (REM_DAY_W'(r1_hour) * REM_DAY_W'(SECS_PER_HOUR));
    assign p_yoe  = 48'(r2_t) * M_365;
    assign p_min  = 48'(r2_mrem) * M_60;
    assign p_y100 = 48'(r3_yoe) * M_100;
    assign c_sec  = r3_mrem - (12'(r3_min) * 12'(SECS_PER_MIN));
    assign c_doy  = r4_doe - (r4_y365 + DOE_W'(r4_y4) - DOE_W'(r4_y100));
    assign p_mp   = 48'(r6_v) * M_153;
    assign p_w5   = 48'(r8_w) * M_5;
    assign c_day  = r8_doy - p_w5[SH_5 +: 9] + 9'd1;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[7:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: leap corrections, hour, era offset in years
            r1_era400 <= p_era[15:0];
            r1_doe    <= i_doe;
            r1_rem    <= i_rem_day;
            r1_a1     <= p_a1[SH_1460 +: 7];
            r1_a2     <= p_a2[SH_36524 +: 3];
            r1_a3     <= (i_doe == DOE_W'(DAYS_PER_ERA - 1));
            r1_hour   <= p_hour[SH_3600 +: 5];

            // stage 2: corrected day count, seconds within the hour
            r2_t      <= r1_doe - DOE_W'(r1_a1) + DOE_W'(r1_a2) - DOE_W'(r1_a3);
            r2_mrem   <= c_mrem[11:0];
            r2_doe    <= r1_doe;
            r2_era400 <= r1_era400;
            r2_hour   <= r1_hour;

            // stage 3: year of era, minute
            r3_yoe    <= p_yoe[SH_365 +: 9];
            r3_min    <= p_min[SH_60 +: 6];
            r3_mrem   <= r2_mrem;
            r3_doe    <= r2_doe;
            r3_era400 <= r2_era400;
            r3_hour   <= r2_hour;

            // stage 4: days before this year of era, base year, second
            r4_y365   <= DOE_W'(r3_yoe) * DOE_W'(365);
            r4_y4     <= r3_yoe[8:2];
            r4_y100   <= p_y100[SH_100 +: 2];
            r4_yb     <= r3_era400 + 16'(r3_yoe);
            r4_sec    <= c_sec[5:0];
            r4_doe    <= r3_doe;
            r4_hour   <= r3_hour;
            r4_min    <= r3_min;

            // stage 5: day of year counted from March 1
            r5_doy    <= c_doy[8:0];
            r5_yb     <= r4_yb;
            r5_hour   <= r4_hour;
            r5_min    <= r4_min;
            r5_sec    <= r4_sec;

            // stage 6: month index numerator
            r6_v      <= 11'(r5_doy) * 11'd5 + 11'd2;
            r6_doy    <= r5_doy;
            r6_yb     <= r5_yb;
            r6_hour   <= r5_hour;
            r6_min    <= r5_min;
            r6_sec    <= r5_sec;

            // stage 7: month index, March is zero
            r7_mp     <= p_mp[SH_153 +: 4];
            r7_doy    <= r6_doy;
            r7_yb     <= r6_yb;
            r7_hour   <= r6_hour;
            r7_min    <= r6_min;
            r7_sec    <= r6_sec;

            // stage 8: month, year bump for January and February
            r8_w      <= 11'(r7_mp) * 11'd153 + 11'd2;
            r8_month  <= (r7_mp < 4'd10) ? r7_mp + 4'd3 : r7_mp - 4'd9;
            r8_year   <= r7_yb + 16'(r7_mp >= 4'd10);
            r8_doy    <= r7_doy;
            r8_hour   <= r7_hour;
            r8_min    <= r7_min;
            r8_sec    <= r7_sec;

            // stage 9: day of month
            r9_res.year   <= r8_year;
            r9_res.month  <= r8_month;
            r9_res.day    <= c_day[4:0];
            r9_res.hour   <= r8_hour;
            r9_res.minute <= r8_min;
            r9_res.second <= r8_sec;
        end
    end

    assign o_valid  = r_vld[8];
    assign o_result = r9_res;

endmodule

// ===== design/epoch_seconds_to_utc_date_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date_core
// Converts signed Unix epoch seconds to a proleptic Gregorian UTC date and
// time of day, fully pipelined.
// ----------------------------------------------------------------------------
// One item enters per clock while the skid entry is free, and one result
// leaves per clock while the receiver is ready. The path runs through the
// input register, the two constant long dividers (days by 675 after a
// seven-bit shift, eras by 146097), which resolve four quotient bits per
// stage, the rebasing register between them, the nine-stage calendar
// pipeline and the output register. A two-entry output buffer lets the
// pipeline keep accepting while a result waits; the whole pipeline holds
// only when both entries are full. Negative epochs fall on the previous day
// with a non-negative time of day; the year wraps to 16 bits.
module epoch_seconds_to_utc_date_core
    import etu_pkg::*;
#(
    parameter int EPOCH_BITS = EPOCH_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave side
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [EPOCH_BITS-1:0] signed epoch count, zero padded to whole bytes
    input  logic [((EPOCH_BITS+7)/8)*8-1:0]      i_s_tdata,
    // master side
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [15:0] year, [19:16] month, [24:20] day, [29:25] hour,
    // [35:30] minute, [41:36] second, [47:42] zero
    output logic [47:0]                          o_m_tdata
);

    // widths and offsets that keep both divisions on non-negative values
    localparam int UW = EPOCH_BITS + 1;
    localparam int N1 = UW - DAY_SHIFT;
    localparam int DW = EPOCH_BITS - 15;
    localparam int ZW = ((DW > 20) ? DW : 20) + 1;
    localparam logic [65:0] KD = ((66'd1 << (EPOCH_BITS - 1)) + 66'(SECS_PER_DAY - 1))
                                 / 66'(SECS_PER_DAY);
    localparam logic [65:0] KB = KD * 66'(SECS_PER_DAY);
    localparam logic [65:0] ED = (KD > 66'(DAYS_TO_1970)) ? KD - 66'(DAYS_TO_1970) : 66'd0;
    localparam logic [65:0] EB = (ED + 66'(DAYS_PER_ERA - 1)) / 66'(DAYS_PER_ERA);
    localparam logic [65:0] CB = 66'(DAYS_TO_1970) + EB * 66'(DAYS_PER_ERA) - KD;

    logic                 w_en;
    logic [65:0]          w_u;
    logic                 r_u_vld;
    logic [UW-1:0]        r_u;

    logic                 d1_vld;
    logic [N1-1:0]        d1_quo;
    logic [9:0]           d1_rem;
    logic [DAY_SHIFT-1:0] d1_low;

    logic                 r_z_vld;
    logic [ZW-1:0]        r_z;
    logic [REM_DAY_W-1:0] r_rem_day;

    logic                 d2_vld;
    logic [ZW-1:0]        d2_quo;
    logic [DOE_W-1:0]     d2_rem;
    logic [REM_DAY_W-1:0] d2_side;

    logic                 civ_vld;
    t_date_time           civ_res;

    logic                 r_out_vld;
    t_date_time           r_out;
    logic                 r_skid_vld;
    t_date_time           r_skid;
    logic                 w_out_free;

    // pipeline advances while the skid entry is free
    assign w_en       = !r_skid_vld;
    assign o_s_tready = w_en;

    // bias the count by a multiple of a day so it is never negative
    assign w_u = 66'(signed'(i_s_tdata[EPOCH_BITS-1:0])) + KB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_vld <= 1'b0;
        end else if (w_en) begin
            r_u_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u <= w_u[UW-1:0];
        end
    end

    // whole days: shifted count by 675, low bits ride along
    etu_cdiv #(
        .NUM_W     (N1),
        .DIVISOR   (DAY_ODD),
        .SIDE_W    (DAY_SHIFT),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_day_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_u_vld),
        .i_num   (r_u[UW-1:DAY_SHIFT]),
        .i_side  (r_u[DAY_SHIFT-1:0]),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_side  (d1_low)
    );

    // day count rebased onto March 1 of year 0 plus whole eras
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_vld <= 1'b0;
        end else if (w_en) begin
            r_z_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z       <= ZW'(d1_quo[DW-1:0]) + CB[ZW-1:0];
            r_rem_day <= {d1_rem, d1_low};
        end
    end

    // eras and day of era
    etu_cdiv #(
        .NUM_W     (ZW),
        .DIVISOR   (DAYS_PER_ERA),
        .SIDE_W    (REM_DAY_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_era_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_z_vld),
        .i_num   (r_z),
        .i_side  (r_rem_day),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    // calendar fields and time of day
    etu_civil u_civil (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (d2_vld),
        .i_era     (d2_quo[15:0] - EB[15:0]),
        .i_doe     (d2_rem),
        .i_rem_day (d2_side),
        .o_valid   (civ_vld),
        .o_result  (civ_res)
    );

    // output register with one skid entry behind it
    assign w_out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_out_free) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_vld <= civ_vld;
        end else if (civ_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_out_free) begin
                r_out <= r_skid;
            end
        end else if (w_out_free) begin
            r_out <= civ_res;
        end else begin
            r_skid <= civ_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_out};

    // skid entry is only ever filled behind a waiting result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid while output register empty");

    // a result arriving at a blocked output lands in the skid entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (civ_vld && !r_skid_vld && r_out_vld && !i_m_tready) |=> r_skid_vld)
        else $error("result lost at blocked output");

    // delivered fields stay within calendar and clock ranges
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out.month >= 4'd1 && r_out.month <= 4'd12 &&
                        r_out.day != 5'd0 && r_out.hour < 5'd24 &&
                        r_out.minute < 6'd60 && r_out.second < 6'd60))
        else $error("output field out of range");

endmodule
